/* rtl/tbde_pkg.sv */
`timescale 1ns / 1ps

package tbde_pkg;

    localparam int NUM_CPUS    = 32;
    localparam int CPU_W       = $clog2(NUM_CPUS);
    localparam int IDX_W       = $clog2(NUM_CPUS + 1);
    localparam int TIME_W      = 63;
    localparam int TICK_W      = 32;
    localparam int FACTOR_W    = 36;
    localparam int DELAY_W     = 40;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 40;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 36'd61496114;
    localparam logic [DELAY_W-1:0]  MIN_RST    = 40'd20000;
    localparam logic [DELAY_W-1:0]  MAX_RST    = 40'd10000000000;

    localparam logic [FUNC_W-1:0] FUNC_ENTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EXIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIRE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PASSED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ENTER,
        OP_EXIT,
        OP_FIRE,
        OP_ZERO
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CPU_W-1:0]   cpu;
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  now;
        logic [TICK_W-1:0]  counter;
    } cmd_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [DELAY_W-1:0]  min_delay;
        logic [DELAY_W-1:0]  max_delay;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_DIFF,
        S_LIMIT,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

endpackage

/* rtl/tbde_if.sv */
`timescale 1ns / 1ps

interface tbde_req_if
    import tbde_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CPU_W-1:0]    cpu;
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   now;
    logic [TICK_W-1:0]   counter;

    modport source (output valid, func, cpu, deadline, now, counter, input ready);
    modport sink   (input valid, func, cpu, deadline, now, counter, output ready);
endinterface

interface tbde_rsp_if
    import tbde_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [NUM_CPUS-1:0]   wake_mask;
    logic                  program_valid;
    logic [TICK_W-1:0]     compare_value;
    logic [TIME_W-1:0]     next_deadline;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, wake_mask, program_valid, compare_value,
                    next_deadline, status, input ready);
    modport sink   (input valid, wake_mask, program_valid, compare_value,
                    next_deadline, status, output ready);
endinterface

/* rtl/timer_broadcast_deadline_engine.sv */
`timescale 1ns / 1ps

// Deadline engine for a shared broadcast comparator. Requests (enter, exit,
// fire) go into a two-entry queue and are executed one at a time by a
// sequencer that owns the member mask, the pending deadline and a 32-entry
// deadline table in RAM; one response comes back per request. Exit, ignored
// and unused requests go straight to the output state; an enter that
// reprograms the comparator passes the subtract, clamp, multiply and add
// stages; a fire first runs the table scan that reads one RAM entry per
// cycle through the single read port, then, if a deadline remains, the same
// reprogram stages. The response register lets the next
// request be accepted while a response waits. Configuration registers (tick
// factor, minimum and maximum delay) must only be written while the engine
// is idle.

module timer_broadcast_deadline_engine
    import tbde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tbde_req_if.sink              req,
    tbde_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FACTOR: cfg_next.factor    = cfg_data[FACTOR_W-1:0];
                CFG_MIN:    cfg_next.min_delay = cfg_data[DELAY_W-1:0];
                CFG_MAX:    cfg_next.max_delay = cfg_data[DELAY_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.factor    <= FACTOR_RST;
            cfg_reg.min_delay <= MIN_RST;
            cfg_reg.max_delay <= MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tbde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    tbde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

/* rtl/tbde_ram.sv */
`timescale 1ns / 1ps

module tbde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* rtl/tbde_front.sv */
`timescale 1ns / 1ps

module tbde_front
    import tbde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tbde_req_if.sink    req,
    output cmd_t        cmd,
    output logic        cmd_valid,
    input  logic        cmd_pop
);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              new_cmd;
    logic              push;

    assign req.ready = (cnt_reg < QCNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // classify the request; a zero deadline on enter/exit is reported and dropped
    always_comb
    begin
        new_cmd.cpu      = req.cpu;
        new_cmd.deadline = req.deadline;
        new_cmd.now      = req.now;
        new_cmd.counter  = req.counter;
        unique case (req.func) inside
            FUNC_ENTER, FUNC_EXIT:
            begin
                if (req.deadline == '0)
                begin
                    new_cmd.op = OP_ZERO;
                end
                else if (req.func == FUNC_ENTER)
                begin
                    new_cmd.op = OP_ENTER;
                end
                else
                begin
                    new_cmd.op = OP_EXIT;
                end
            end
            FUNC_FIRE: new_cmd.op = OP_FIRE;
            default:   new_cmd.op = OP_NOP;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(cmd_pop && cmd_valid))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && cmd_pop && cmd_valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

/* rtl/tbde_back.sv */
`timescale 1ns / 1ps

module tbde_back
    import tbde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    input  logic        cmd_valid,
    output logic        cmd_pop,
    tbde_rsp_if.source  rsp
);

    state_t              state_reg, state_next;
    logic [NUM_CPUS-1:0] mask_reg, mask_next;
    logic [TIME_W-1:0]   pending_reg, pending_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TICK_W-1:0]   counter_reg, counter_next;
    logic [TIME_W-1:0]   expire_reg, expire_next;
    logic                passed_reg, passed_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                rvalid_reg, rvalid_next;
    logic [CPU_W-1:0]    ridx_reg, ridx_next;
    logic [NUM_CPUS-1:0] wake_reg, wake_next;
    logic [TIME_W-1:0]   soonest_reg, soonest_next;
    logic [TIME_W-1:0]   diff_reg, diff_next;
    logic [DELAY_W-1:0]  delta_reg, delta_next;
    logic [63:0]         p00_reg, p00_next;
    logic [35:0]         p01_reg, p01_next;
    logic [39:0]         p10_reg, p10_next;
    logic                prog_reg, prog_next;
    logic [TICK_W-1:0]   cmp_reg, cmp_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                ovalid_reg, ovalid_next;
    logic [NUM_CPUS-1:0] owake_reg;
    logic                oprog_reg;
    logic [TICK_W-1:0]   ocmp_reg;
    logic [TIME_W-1:0]   onext_reg;
    logic [STATUS_W-1:0] ostatus_reg;
    logic                oload;

    logic                ram_we;
    logic                ram_re;
    logic [TIME_W-1:0]   ram_rdata;

    tbde_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_CPUS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.cpu),
        .wdata (cmd.deadline),
        .re    (ram_re),
        .raddr (idx_reg[CPU_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rsp.valid         = ovalid_reg;
    assign rsp.wake_mask     = owake_reg;
    assign rsp.program_valid = oprog_reg;
    assign rsp.compare_value = ocmp_reg;
    assign rsp.next_deadline = onext_reg;
    assign rsp.status        = ostatus_reg;

    always_comb
    begin
        logic [TIME_W-1:0] lim;

        state_next   = state_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        now_next     = now_reg;
        counter_next = counter_reg;
        expire_next  = expire_reg;
        passed_next  = passed_reg;
        idx_next     = idx_reg;
        rvalid_next  = 1'b0;
        ridx_next    = ridx_reg;
        wake_next    = wake_reg;
        soonest_next = soonest_reg;
        diff_next    = diff_reg;
        delta_next   = delta_reg;
        p00_next     = p00_reg;
        p01_next     = p01_reg;
        p10_next     = p10_reg;
        prog_next    = prog_reg;
        cmp_next     = cmp_reg;
        status_next  = status_reg;
        cmd_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        oload        = 1'b0;
        ovalid_next  = rsp.ready ? 1'b0 : ovalid_reg;
        lim          = diff_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    now_next     = cmd.now;
                    counter_next = cmd.counter;
                    wake_next    = '0;
                    prog_next    = 1'b0;
                    cmp_next     = '0;
                    status_next  = ST_OK;
                    state_next   = S_OUT;
                    case (cmd.op)
                        OP_ENTER:
                        begin
                            ram_we    = 1'b1;
                            mask_next = mask_reg | (NUM_CPUS'(1) << cmd.cpu);
                            // earlier than the pending one: forced reprogram
                            if (cmd.deadline < pending_reg)
                            begin
                                pending_next = cmd.deadline;
                                expire_next  = cmd.deadline;
                                passed_next  = (cmd.deadline <= cmd.now);
                                state_next   = S_DIFF;
                            end
                        end
                        OP_EXIT:
                        begin
                            mask_next = mask_reg & ~(NUM_CPUS'(1) << cmd.cpu);
                        end
                        OP_ZERO:
                        begin
                            status_next = ST_IGNORED;
                        end
                        OP_FIRE:
                        begin
                            pending_next = TIME_MAX;
                            soonest_next = TIME_MAX;
                            idx_next     = '0;
                            state_next   = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // read one entry per cycle, evaluate it the cycle after
                if (idx_reg < IDX_W'(NUM_CPUS))
                begin
                    ram_re      = 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = idx_reg[CPU_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                end
                if (rvalid_reg && mask_reg[ridx_reg])
                begin
                    if (ram_rdata <= now_reg)
                    begin
                        wake_next[ridx_reg] = 1'b1;
                    end
                    else if (ram_rdata < soonest_reg)
                    begin
                        soonest_next = ram_rdata;
                    end
                end
                if (!(idx_reg < IDX_W'(NUM_CPUS)) && !rvalid_reg)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (soonest_reg != TIME_MAX)
                begin
                    pending_next = soonest_reg;
                    expire_next  = soonest_reg;
                    passed_next  = 1'b0;
                    state_next   = S_DIFF;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIFF:
            begin
                prog_next   = 1'b1;
                status_next = passed_reg ? ST_PASSED : ST_OK;
                if (expire_reg == TIME_MAX)
                begin
                    cmp_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    diff_next  = passed_reg ? '0 : expire_reg - now_reg;
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                // max clamp first, min clamp wins
                if (lim > TIME_W'(cfg.max_delay))
                begin
                    lim = TIME_W'(cfg.max_delay);
                end
                if (lim < TIME_W'(cfg.min_delay))
                begin
                    lim = TIME_W'(cfg.min_delay);
                end
                delta_next = lim[DELAY_W-1:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // partial products of delta * factor; the high-high term only
                // reaches bits above the 32-bit tick window
                p00_next   = delta_reg[31:0] * cfg.factor[31:0];
                p01_next   = delta_reg[31:0] * cfg.factor[FACTOR_W-1:32];
                p10_next   = delta_reg[DELAY_W-1:32] * cfg.factor[31:0];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmp_next   = counter_reg + p00_reg[63:32] + p01_reg[31:0] + p10_reg[31:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    oload       = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mask_reg    <= '0;
            pending_reg <= TIME_MAX;
            idx_reg     <= '0;
            rvalid_reg  <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
            idx_reg     <= idx_next;
            rvalid_reg  <= rvalid_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        counter_reg <= counter_next;
        expire_reg  <= expire_next;
        passed_reg  <= passed_next;
        ridx_reg    <= ridx_next;
        wake_reg    <= wake_next;
        soonest_reg <= soonest_next;
        diff_reg    <= diff_next;
        delta_reg   <= delta_next;
        p00_reg     <= p00_next;
        p01_reg     <= p01_next;
        p10_reg     <= p10_next;
        prog_reg    <= prog_next;
        cmp_reg     <= cmp_next;
        status_reg  <= status_next;
        if (oload)
        begin
            owake_reg   <= wake_reg;
            oprog_reg   <= prog_reg;
            ocmp_reg    <= cmp_reg;
            onext_reg   <= pending_reg;
            ostatus_reg <= status_reg;
        end
    end

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !ram_we)
        else $error("table written during scan");

    a_mask_stable_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && $past(state_reg == S_SCAN) |-> $stable(mask_reg))
        else $error("member mask changed during scan");

    a_prog_not_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && oprog_reg |-> ostatus_reg != ST_IGNORED)
        else $error("comparator written on an ignored request");

    a_fire_prog_ok: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && owake_reg != '0 |-> !oprog_reg || ostatus_reg == ST_OK)
        else $error("fire reprogrammed with a passed deadline");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result posted outside the output state");

endmodule

/* tb/sv/timer_broadcast_deadline_engine_tb.sv */
`timescale 1ns / 1ps

module timer_broadcast_deadline_engine_tb;
    import tbde_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam logic [FACTOR_W-1:0] FACTOR_ONES = '1;
    localparam logic [DELAY_W-1:0]  DELAY_ONES  = '1;

    typedef struct packed {
        logic [NUM_CPUS-1:0] wake_mask;
        logic                program_valid;
        logic [TICK_W-1:0]   compare_value;
        logic [TIME_W-1:0]   next_deadline;
        logic [STATUS_W-1:0] status;
    } wake_result_t;

    class deadline_scoreboard;
        bit [FACTOR_W-1:0] factor;
        bit [DELAY_W-1:0]  min_dly;
        bit [DELAY_W-1:0]  max_dly;
        bit [NUM_CPUS-1:0] members;
        bit [TIME_W-1:0]   dl_table [NUM_CPUS];
        bit [TIME_W-1:0]   pending;
        wake_result_t      expected_q [$];
        int                errors;

        function new();
            factor  = FACTOR_RST;
            min_dly = MIN_RST;
            max_dly = MAX_RST;
            members = '0;
            pending = TIME_MAX;
            errors  = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FACTOR: factor  = data[FACTOR_W-1:0];
                CFG_MIN:    min_dly = data[DELAY_W-1:0];
                CFG_MAX:    max_dly = data[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        // clamp, scale by factor >> 32 and add to the tick counter
        function bit [STATUS_W-1:0] program_comparator(bit [TIME_W-1:0] expire,
                                                       bit [TIME_W-1:0] t_now, bit forced,
                                                       bit [TICK_W-1:0] counter,
                                                       inout wake_result_t r);
            bit        passed;
            bit [63:0] delta;
            bit [75:0] prod;
            passed = (expire <= t_now);
            if (expire == 0)
                return ST_OK;
            if (passed && !forced)
                return ST_PASSED;
            pending = expire;
            r.program_valid = 1'b1;
            if (expire == TIME_MAX)
            begin
                r.compare_value = '0;
                return passed ? ST_PASSED : ST_OK;
            end
            delta = passed ? 64'd0 : 64'(expire - t_now);
            if (delta > max_dly)
                delta = max_dly;
            if (delta < min_dly)
                delta = min_dly;
            prod = 76'(delta) * 76'(factor);
            r.compare_value = counter + prod[63:32];
            return passed ? ST_PASSED : ST_OK;
        endfunction

        function void note_request(bit [FUNC_W-1:0] func, bit [CPU_W-1:0] cpu,
                                   bit [TIME_W-1:0] dl, bit [TIME_W-1:0] t_now,
                                   bit [TICK_W-1:0] counter);
            wake_result_t        r;
            bit [TIME_W-1:0]     nearest;
            bit [STATUS_W-1:0]   st;
            r  = '0;
            st = ST_OK;
            case (func) inside
                FUNC_ENTER, FUNC_EXIT:
                begin
                    if (dl == 0)
                        st = ST_IGNORED;
                    else if (func == FUNC_ENTER)
                    begin
                        dl_table[cpu] = dl;
                        members[cpu]  = 1'b1;
                        if (dl < pending)
                            st = program_comparator(dl, t_now, 1'b1, counter, r);
                    end
                    else
                        members[cpu] = 1'b0;
                end
                FUNC_FIRE:
                begin
                    pending = TIME_MAX;
                    nearest = TIME_MAX;
                    for (int i = 0; i < NUM_CPUS; i++)
                    begin
                        if (!members[i])
                            continue;
                        if (dl_table[i] <= t_now)
                            r.wake_mask[i] = 1'b1;
                        else if (dl_table[i] < nearest)
                            nearest = dl_table[i];
                    end
                    if (nearest != TIME_MAX)
                        st = program_comparator(nearest, t_now, 1'b0, counter, r);
                end
                default: ;
            endcase
            r.status        = st;
            r.next_deadline = pending;
            expected_q.push_back(r);
        endfunction

        function void check_response(wake_result_t got);
            wake_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.wake_mask !== want.wake_mask)
            begin
                $error("wake_mask: expected %h, got %h", want.wake_mask, got.wake_mask);
                errors++;
            end
            if (got.program_valid !== want.program_valid)
            begin
                $error("program_valid: expected %b, got %b", want.program_valid,
                       got.program_valid);
                errors++;
            end
            if (got.compare_value !== want.compare_value)
            begin
                $error("compare_value: expected %h, got %h", want.compare_value,
                       got.compare_value);
                errors++;
            end
            if (got.next_deadline !== want.next_deadline)
            begin
                $error("next_deadline: expected %h, got %h", want.next_deadline,
                       got.next_deadline);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tbde_req_if req_ch ();
    tbde_rsp_if rsp_ch ();

    timer_broadcast_deadline_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    deadline_scoreboard sb;
    bit                 steady;
    bit [TIME_W-1:0]    clock_ns;
    int                 stall_cycles;

    always #2 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= steady || ($urandom_range(99) >= 20);
    end

    // response check and no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response({rsp_ch.wake_mask, rsp_ch.program_valid,
                                   rsp_ch.compare_value, rsp_ch.next_deadline,
                                   rsp_ch.status});
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic bit [TIME_W-1:0] rand_time();
        bit [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    task automatic send_request(bit [FUNC_W-1:0] f, bit [CPU_W-1:0] c,
                                bit [TIME_W-1:0] dl, bit [TIME_W-1:0] t_now,
                                bit [TICK_W-1:0] cnt);
        if (!steady && $urandom_range(99) < 20)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= f;
        req_ch.cpu      <= c;
        req_ch.deadline <= dl;
        req_ch.now      <= t_now;
        req_ch.counter  <= cnt;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(f, c, dl, t_now, cnt);
    endtask

    // hold off requests until every response is back; the engine is idle then
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_config(bit [FACTOR_W-1:0] f, bit [DELAY_W-1:0] mn,
                                bit [DELAY_W-1:0] mx);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FACTOR;
        cfg_data  <= CFG_DATA_W'(f);
        sb.set_config(CFG_FACTOR, CFG_DATA_W'(f));
        @(posedge clk);
        cfg_index <= CFG_MIN;
        cfg_data  <= mn;
        sb.set_config(CFG_MIN, mn);
        @(posedge clk);
        cfg_index <= CFG_MAX;
        cfg_data  <= mx;
        sb.set_config(CFG_MAX, mx);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly sleep/wake traffic around a running clock, some noise
    task automatic random_item();
        int               kind;
        int               pick;
        bit [TIME_W-1:0]  dl;
        bit [CPU_W-1:0]   c;
        kind = $urandom_range(99);
        pick = $urandom_range(9);
        c    = CPU_W'($urandom);
        if ($urandom_range(7) == 0)
            clock_ns += TIME_W'({$urandom_range(3), $urandom});
        else
            clock_ns += TIME_W'($urandom_range(60000));
        if (kind < 40)
        begin
            case (pick)
                0:       dl = '0;
                1:       dl = clock_ns - TIME_W'($urandom_range(100000));
                7:       dl = clock_ns + TIME_W'({$urandom_range(7), $urandom});
                8:       dl = rand_time();
                9:       dl = TIME_MAX;
                default: dl = clock_ns + TIME_W'($urandom_range(1, 200000));
            endcase
            send_request(FUNC_ENTER, c, dl, clock_ns, $urandom);
        end
        else if (kind < 55)
            send_request(FUNC_EXIT, c, (pick == 0) ? '0 : rand_time(), clock_ns, $urandom);
        else if (kind < 88)
            send_request(FUNC_FIRE, c, rand_time(), clock_ns, $urandom);
        else if (kind < 92)
            send_request(FUNC_UNUSED, c, rand_time(), rand_time(), $urandom);
        else
            send_request(FUNC_W'($urandom), c, rand_time(), rand_time(), $urandom);
    endtask

    task automatic random_phase(int count);
        clock_ns = TIME_W'({$urandom_range(255, 1), $urandom});
        repeat (count) random_item();
        drain();
    endtask

    initial
    begin
        bit [TIME_W-1:0] base;
        base = 63'd1_000_000_000_000;
        sb = new();
        steady = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FACTOR;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_ENTER;
        req_ch.cpu = '0;
        req_ch.deadline = '0;
        req_ch.now = '0;
        req_ch.counter = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty fire, ignored zero deadline, unused func
        send_request(FUNC_FIRE, 5'd0, '0, base, '0);
        send_request(FUNC_EXIT, 5'd7, '0, base, 32'h1);
        send_request(FUNC_ENTER, 5'd7, '0, base, 32'h2);
        send_request(FUNC_UNUSED, 5'd31, TIME_MAX, TIME_MAX, '1);
        // clamp to max, plain, clamp to min, forced past deadlines, never
        send_request(FUNC_ENTER, 5'd0, base + 63'd30_000_000_000, base, '1);
        send_request(FUNC_ENTER, 5'd1, base + 63'd50_000, base, 32'h1234_5678);
        send_request(FUNC_ENTER, 5'd31, base + 63'd1, base, 32'h8000_0000);
        send_request(FUNC_ENTER, 5'd2, base - 63'd5, base, 32'hdead_beef);
        send_request(FUNC_ENTER, 5'd3, TIME_MAX, base, 32'h5555_5555);
        send_request(FUNC_ENTER, 5'd4, 63'd1, base, 32'haaaa_aaaa);
        send_request(FUNC_EXIT, 5'd4, 63'd77, base, 32'h0);
        send_request(FUNC_EXIT, 5'd9, TIME_MAX, base, 32'h0);
        send_request(FUNC_FIRE, 5'd0, '0, base + 63'd100_000, 32'h0102_0304);
        send_request(FUNC_ENTER, 5'd16, base + 63'd200_000, base + 63'd150_000, '1);
        send_request(FUNC_FIRE, 5'd5, TIME_MAX, base + 63'd10, 32'hffff_0000);
        send_request(FUNC_FIRE, 5'd31, '0, TIME_MAX, '1);
        send_request(FUNC_ENTER, 5'd31, TIME_MAX - 63'd1, '0, '1);
        send_request(FUNC_EXIT, 5'd31, TIME_MAX, '0, '0);
        send_request(FUNC_FIRE, 5'd0, '0, '0, '0);
        drain();

        random_phase(100);
        apply_config(FACTOR_ONES, '0, DELAY_ONES);
        random_phase(90);
        // minimum above maximum: the minimum wins
        apply_config('0, DELAY_ONES, '0);
        random_phase(60);
        apply_config(36'h1_0000_0000, 40'd100, 40'd1_000_000);
        steady = 1'b1;
        random_phase(100);
        steady = 1'b0;
        apply_config(FACTOR_W'({$urandom_range(15), $urandom}),
                     DELAY_W'($urandom_range(200000)),
                     {8'($urandom), $urandom});
        random_phase(100);
        apply_config(FACTOR_ONES, DELAY_ONES, DELAY_ONES);
        random_phase(40);
        apply_config(FACTOR_W'({$urandom_range(15), $urandom}),
                     DELAY_W'($urandom_range(50000)),
                     DELAY_W'({$urandom_range(3), $urandom}));
        random_phase(60);

        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
